/* hw/rtl/arbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arbp_pkg
// Shared widths, defaults, types and helpers for the allele row bit-plane
// packer.
// ----------------------------------------------------------------------------
package arbp_pkg;

	localparam int CODE_W = 7;   // allele code and row width register
	localparam int ROW_W  = 64;  // packed plane row
	localparam int NUM_W  = 3;   // plane number and plane total

	localparam int MAX_COLUMNS_DEF = 64;
	localparam int MAX_PLANES_DEF  = 7;

	localparam logic [CODE_W-1:0] ROW_WIDTH_RST = CODE_W'(64);

	// status from the accumulator toward the result buffer
	typedef struct packed {
		logic             last_col;     // next beat closes the row
		logic [NUM_W-1:0] plane_total;  // planes that row would emit
	} acc_status_t;

	// bit length of a code, zero for zero
	function automatic logic [NUM_W-1:0] bit_len(input logic [CODE_W-1:0] v);
		logic [NUM_W-1:0] n;
		n = '0;
		for (int i = 0; i < CODE_W; i++) begin
			if (v[i]) begin
				n = NUM_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/arbp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arbp channel interfaces
// Valid/ready channels for allele codes in and packed plane rows out.
// ----------------------------------------------------------------------------
interface arbp_in_if;
	logic                        valid;
	logic                        ready;
	logic [arbp_pkg::CODE_W-1:0] allele_code;

	modport source (output valid, output allele_code, input ready);
	modport sink (input valid, input allele_code, output ready);
endinterface

interface arbp_out_if;
	logic                       valid;
	logic                       ready;
	logic [arbp_pkg::ROW_W-1:0] plane_row;
	logic [arbp_pkg::NUM_W-1:0] plane_number;
	logic [arbp_pkg::NUM_W-1:0] plane_total;
	logic                       final_plane;

	modport source (output valid, output plane_row, output plane_number,
		output plane_total, output final_plane, input ready);
	modport sink (input valid, input plane_row, input plane_number,
		input plane_total, input final_plane, output ready);
endinterface
`default_nettype wire

/* hw/rtl/arbp_plane_acc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arbp_plane_acc
// Per-row accumulator: column position, row peak and one bit row per plane.
// Shows the planes as they stand after the current beat so the row end can
// be captured in the same cycle.
// ----------------------------------------------------------------------------
module arbp_plane_acc #(
	parameter int MAX_COLUMNS = arbp_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_PLANES  = arbp_pkg::MAX_PLANES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [arbp_pkg::CODE_W-1:0]       row_width,
	input  wire logic                              accept,
	input  wire logic [arbp_pkg::CODE_W-1:0]       allele_code,
	output arbp_pkg::acc_status_t                  status,
	output logic [MAX_PLANES-1:0][arbp_pkg::ROW_W-1:0] planes_nx
);

	localparam int COL_W = $clog2(MAX_COLUMNS);

	logic [COL_W-1:0]                   col_q;
	logic [arbp_pkg::CODE_W-1:0]        peak_q;
	logic [MAX_PLANES-1:0][arbp_pkg::ROW_W-1:0] planes_q;

	logic [arbp_pkg::CODE_W-1:0] eff_w;
	logic [arbp_pkg::CODE_W-1:0] col_p1;
	logic [arbp_pkg::CODE_W-1:0] peak_nx;
	logic [arbp_pkg::ROW_W-1:0]  col_mask;
	logic [arbp_pkg::NUM_W-1:0]  peak_len;

	// zero width acts as one, widths past the storage saturate
	always_comb begin
		if (row_width == '0) begin
			eff_w = arbp_pkg::CODE_W'(1);
		end else if (row_width > arbp_pkg::CODE_W'(MAX_COLUMNS)) begin
			eff_w = arbp_pkg::CODE_W'(MAX_COLUMNS);
		end else begin
			eff_w = row_width;
		end
	end

	assign col_p1   = arbp_pkg::CODE_W'(col_q) + arbp_pkg::CODE_W'(1);
	// column j lands at bit 63-j
	assign col_mask = {1'b1, {(arbp_pkg::ROW_W-1){1'b0}}} >> col_q;
	assign peak_nx  = (allele_code > peak_q) ? allele_code : peak_q;

	always_comb begin
		for (int k = 0; k < MAX_PLANES; k++) begin
			planes_nx[k] = planes_q[k] | (allele_code[k] ? col_mask : '0);
		end
	end

	assign peak_len = arbp_pkg::bit_len(peak_nx);

	always_comb begin
		status.last_col = (col_p1 >= eff_w);
		if (peak_len == '0) begin
			status.plane_total = arbp_pkg::NUM_W'(1);
		end else if (peak_len > arbp_pkg::NUM_W'(MAX_PLANES)) begin
			status.plane_total = arbp_pkg::NUM_W'(MAX_PLANES);
		end else begin
			status.plane_total = peak_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			peak_q   <= '0;
			planes_q <= '0;
		end else if (accept) begin
			if (status.last_col) begin
				col_q    <= '0;
				peak_q   <= '0;
				planes_q <= '0;
			end else begin
				col_q    <= col_p1[COL_W-1:0];
				peak_q   <= peak_nx;
				planes_q <= planes_nx;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/allele_row_bit_plane_packer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// allele_row_bit_plane_packer
// Streams allele codes of a variant row into bit planes and emits one packed
// row per plane, lowest plane first, after the row's last column.
// ----------------------------------------------------------------------------
// One allele code is taken per cycle unless a row end stalls the input; each
// beat ORs its bits into the plane rows directly, so no walk over stored
// columns follows. At the row's last column the finished planes move into a
// result buffer and drain as plane_total output beats (1 to MAX_PLANES), one
// per cycle while the sink is ready, while the next row already streams in.
// The result buffer holds one row: a row end that arrives before the previous
// row's last plane beat has left stalls the input until that beat is taken.
// Row width must be written through cfg_we / cfg_wdata only while the block
// is idle; the block itself does not enforce this. Zero acts as one.
// ----------------------------------------------------------------------------
module allele_row_bit_plane_packer #(
	parameter int MAX_COLUMNS = arbp_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_PLANES  = arbp_pkg::MAX_PLANES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [arbp_pkg::CODE_W-1:0] cfg_wdata,
	arbp_in_if.sink                          in_ch,
	arbp_out_if.source                       out_ch
);

	localparam int PIDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

	logic [arbp_pkg::CODE_W-1:0] row_width_q;

	arbp_pkg::acc_status_t                      status;
	logic [MAX_PLANES-1:0][arbp_pkg::ROW_W-1:0] planes_nx;

	logic [MAX_PLANES-1:0][arbp_pkg::ROW_W-1:0] buf_q;
	logic [arbp_pkg::NUM_W-1:0]                 cnt_q;
	logic [arbp_pkg::NUM_W-1:0]                 idx_q;
	logic                                       busy_q;

	logic accept;
	logic load;
	logic is_final;
	logic drain_last;
	logic buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= arbp_pkg::ROW_WIDTH_RST;
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	arbp_plane_acc #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_PLANES  (MAX_PLANES)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_width   (row_width_q),
		.accept      (accept),
		.allele_code (in_ch.allele_code),
		.status      (status),
		.planes_nx   (planes_nx)
	);

	assign is_final   = (idx_q + arbp_pkg::NUM_W'(1)) == cnt_q;
	assign drain_last = busy_q && out_ch.ready && is_final;
	assign buf_free   = !busy_q || drain_last;

	// only a row-closing beat needs room in the result buffer
	assign in_ch.ready = buf_free || !status.last_col;
	assign accept      = in_ch.valid && in_ch.ready;
	assign load        = accept && status.last_col;

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= planes_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= arbp_pkg::NUM_W'(1);
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			cnt_q  <= status.plane_total;
		end else if (busy_q && out_ch.ready) begin
			idx_q <= idx_q + arbp_pkg::NUM_W'(1);
			if (is_final) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = busy_q;
	assign out_ch.plane_row    = buf_q[idx_q[PIDX_W-1:0]];
	assign out_ch.plane_number = idx_q;
	assign out_ch.plane_total  = cnt_q;
	assign out_ch.final_plane  = is_final;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < cnt_q) && (cnt_q != '0)
			&& (cnt_q <= arbp_pkg::NUM_W'(MAX_PLANES)))
		else $error("plane index outside the row's plane count");

	a_load_starts_row: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_ch.valid && (idx_q == '0))
		else $error("row end did not start a plane burst at plane zero");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_last && !load) |=> !out_ch.valid)
		else $error("result still valid after the final plane beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !drain_last) |-> !load)
		else $error("result buffer reloaded while planes remain");
`endif

endmodule
`default_nettype wire
